// File: hw/rtl/approx_median_background_subtract_assert.svh
// assertion macros shared by the approximate-median background subtractor checkers
`ifndef APPROX_MEDIAN_BACKGROUND_SUBTRACT_ASSERT_SVH
`define APPROX_MEDIAN_BACKGROUND_SUBTRACT_ASSERT_SVH

// clocked assertion, switched off while reset is applied
`define AMBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked assertion that also sees the reset edges
`define AMBS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ambs_pkg.sv
// types, constants and helpers of the approximate-median background subtractor
package ambs_pkg;

	localparam int unsigned FRAME_PIXELS = 1048576;
	localparam int unsigned FRACTION_BITS = 4;

	localparam int unsigned IDX_W = 20;
	localparam int unsigned ADDR_W = $clog2(FRAME_PIXELS);
	localparam int unsigned PIX_W = 8;
	localparam int unsigned FRAC_W = FRACTION_BITS;
	localparam int unsigned FIX_W = PIX_W + FRAC_W;
	localparam int unsigned CH_N = 3;
	localparam int unsigned CFG_W = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned SUM_W = (FIX_W > CFG_W ? FIX_W : CFG_W) + 1;

	// stream word layout
	localparam int unsigned IN_FIELDS_W = IDX_W + 3 * PIX_W + 1;
	localparam int unsigned IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = 1 + IDX_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	// luma conversion
	localparam int unsigned Y_SHIFT = 14;
	localparam int unsigned GRAY_SUM_W = PIX_W + Y_SHIFT;
	localparam logic [GRAY_SUM_W-1:0] B2Y = GRAY_SUM_W'(1868);
	localparam logic [GRAY_SUM_W-1:0] G2Y = GRAY_SUM_W'(9617);
	localparam logic [GRAY_SUM_W-1:0] R2Y = GRAY_SUM_W'(4899);

	// largest background value, 255 in fixed point
	localparam logic [FIX_W-1:0] FIX_TOP = FIX_W'((1 << FIX_W) - (1 << FRAC_W));

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DETECT = 1'b1;

	localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BGR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COLOR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADAPT_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 2'd2;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(480);
	localparam logic [CFG_W-1:0] ADAPT_STEP_RST = CFG_W'(16);
	localparam logic [MODE_W-1:0] PIXEL_MODE_RST = MODE_GRAY;

	typedef logic [CH_N-1:0][FIX_W-1:0] chan_vec_t;

	function automatic logic [FIX_W-1:0] to_fix(input logic [PIX_W-1:0] p);
		return FIX_W'(p) << FRAC_W;
	endfunction

endpackage

// File: hw/rtl/ambs_chan.sv
// per-channel compare against the background and one adaption step with clamping
module ambs_chan (
	input  logic [ambs_pkg::FIX_W-1:0] pix,
	input  logic [ambs_pkg::FIX_W-1:0] bg,
	input  logic [ambs_pkg::CFG_W-1:0] threshold,
	input  logic [ambs_pkg::CFG_W-1:0] step,
	output logic                       fg,
	output logic [ambs_pkg::FIX_W-1:0] nb
);
	import ambs_pkg::*;

	logic [FIX_W-1:0] diff;
	logic [SUM_W-1:0] bg_ext;
	logic [SUM_W-1:0] step_ext;
	logic [SUM_W-1:0] moved;

	assign diff = (pix > bg) ? (pix - bg) : (bg - pix);
	assign fg = SUM_W'(diff) > SUM_W'(threshold);

	assign bg_ext = SUM_W'(bg);
	assign step_ext = SUM_W'(step);

	always_comb begin
		if (bg < pix) begin
			moved = bg_ext + step_ext;
		end else if (bg > pix) begin
			// stepping below zero clamps to zero
			moved = (bg_ext >= step_ext) ? (bg_ext - step_ext) : '0;
		end else begin
			moved = bg_ext;
		end
		nb = (moved > SUM_W'(FIX_TOP)) ? FIX_TOP : moved[FIX_W-1:0];
	end

endmodule

// File: hw/rtl/approx_median_background_subtract.sv
// approximate-median background subtractor: one pixel word in, one flag word per detect
// a detect word passes stage 1, stage 2 and the output register on its way to m_axis
// throughput: one word per cycle unless a result is stalled; the background store is a single-port-write,
// one-read memory with a two-stage read-modify-write and same-pixel forwarding
// reset: registers go to threshold 480, adapt step 16, gray mode; pipeline empties; the background
// store is not cleared and the block does not check it, so the user loads every pixel before it is detected
module approx_median_background_subtract (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// pixel_index, blue_or_gray, green, red, update, zero fill
	input  logic [ambs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// op
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// foreground, pixel_out_index, zero fill
	output logic [ambs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [ambs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ambs_pkg::CFG_W-1:0]         cfg_data
);
	import ambs_pkg::*;

	// configuration
	logic [CFG_W-1:0]  threshold_q;
	logic [CFG_W-1:0]  adapt_step_q;
	logic [MODE_W-1:0] mode_q;
	logic              color_mode;
	logic              bgr_mode;

	// input word fields
	logic [IDX_W-1:0] in_index;
	logic [PIX_W-1:0] in_blue;
	logic [PIX_W-1:0] in_green;
	logic [PIX_W-1:0] in_red;
	logic             in_update;
	logic             in_acc;

	// flow control
	logic out_free;
	logic s2_go;
	logic s2_free;
	logic s1_free;

	// stage 1
	logic             s1_valid;
	logic             s1_op;
	logic [IDX_W-1:0] s1_index;
	logic [PIX_W-1:0] s1_blue;
	logic [PIX_W-1:0] s1_green;
	logic [PIX_W-1:0] s1_red;
	logic             s1_update;
	chan_vec_t        rd_data_s1;
	logic [GRAY_SUM_W-1:0] gray_sum;
	logic [PIX_W-1:0] ch0_pix;
	chan_vec_t        pix_fix;
	chan_vec_t        bg_fwd;
	logic [CH_N-1:0]  s1_mask;
	logic             s1_in_range;
	logic [ADDR_W-1:0] s1_addr;

	// stage 2
	logic             s2_valid;
	logic             s2_op;
	logic [IDX_W-1:0] s2_index;
	logic             s2_update;
	logic             s2_in_range;
	logic             s2_color;
	logic [CH_N-1:0]  s2_mask;
	chan_vec_t        pix_s2;
	chan_vec_t        bg_s2;
	chan_vec_t        nb;
	logic [CH_N-1:0]  fg_ch;
	logic             s2_fg;
	logic             s2_wr;
	chan_vec_t        wr_data;
	logic [ADDR_W-1:0] s2_addr;

	// last write into the store
	logic              wb_valid_q;
	logic [ADDR_W-1:0] wb_addr_q;
	logic [CH_N-1:0]   wb_mask_q;
	chan_vec_t         wb_data_q;

	// output register
	logic             out_valid_q;
	logic             out_fg_q;
	logic [IDX_W-1:0] out_index_q;

	chan_vec_t bg_mem [FRAME_PIXELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			adapt_step_q <= ADAPT_STEP_RST;
			mode_q <= PIXEL_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:  threshold_q <= cfg_data;
				REG_ADAPT_STEP: adapt_step_q <= cfg_data;
				REG_PIXEL_MODE: mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// the unused mode code acts as plain gray
	assign color_mode = (mode_q == MODE_COLOR);
	assign bgr_mode = (mode_q == MODE_BGR);

	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_blue = s_axis_tdata[IDX_W +: PIX_W];
	assign in_green = s_axis_tdata[IDX_W + PIX_W +: PIX_W];
	assign in_red = s_axis_tdata[IDX_W + 2 * PIX_W +: PIX_W];
	assign in_update = s_axis_tdata[IDX_W + 3 * PIX_W];

	// loads leave stage 2 without needing the output register
	assign out_free = !out_valid_q || m_axis_tready;
	assign s2_go = s2_valid && ((s2_op == OP_LOAD) || out_free);
	assign s2_free = !s2_valid || s2_go;
	assign s1_free = !s1_valid || s2_free;
	assign s_axis_tready = s1_free;
	assign in_acc = s_axis_tvalid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			out_valid_q <= 1'b0;
			wb_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid <= s_axis_tvalid;
			end
			if (s2_free) begin
				s2_valid <= s1_valid;
			end
			if (out_free) begin
				out_valid_q <= s2_valid && (s2_op == OP_DETECT);
			end
			if (s2_go && s2_wr) begin
				wb_valid_q <= 1'b1;
			end
		end
	end

	// stage 1 payload and store read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_op <= s_axis_tuser;
			s1_index <= in_index;
			s1_blue <= in_blue;
			s1_green <= in_green;
			s1_red <= in_red;
			s1_update <= in_update;
			rd_data_s1 <= bg_mem[in_index[ADDR_W-1:0]];
		end
	end

	assign gray_sum = B2Y * GRAY_SUM_W'(s1_blue) + G2Y * GRAY_SUM_W'(s1_green)
		+ R2Y * GRAY_SUM_W'(s1_red);
	assign ch0_pix = bgr_mode ? gray_sum[Y_SHIFT +: PIX_W] : s1_blue;
	assign pix_fix[0] = to_fix(ch0_pix);
	assign pix_fix[1] = to_fix(s1_green);
	assign pix_fix[2] = to_fix(s1_red);
	assign s1_mask = color_mode ? {CH_N{1'b1}} : CH_N'(1);
	assign s1_in_range = 32'(s1_index) < 32'(FRAME_PIXELS);
	assign s1_addr = s1_index[ADDR_W-1:0];
	assign s2_addr = s2_index[ADDR_W-1:0];

	// newest value per channel: write leaving stage 2, then last write, then the store
	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			if (s2_valid && s2_wr && (s2_addr == s1_addr) && s2_mask[c]) begin
				bg_fwd[c] = wr_data[c];
			end else if (wb_valid_q && (wb_addr_q == s1_addr) && wb_mask_q[c]) begin
				bg_fwd[c] = wb_data_q[c];
			end else begin
				bg_fwd[c] = rd_data_s1[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s2_free) begin
			s2_op <= s1_op;
			s2_index <= s1_index;
			s2_update <= s1_update;
			s2_in_range <= s1_in_range;
			s2_color <= color_mode;
			s2_mask <= s1_mask;
			pix_s2 <= pix_fix;
			bg_s2 <= bg_fwd;
		end
	end

	// stage 2: compare and adapt
	for (genvar c = 0; c < CH_N; c++) begin : g_chan
		ambs_chan u_chan (
			.pix       (pix_s2[c]),
			.bg        (bg_s2[c]),
			.threshold (threshold_q),
			.step      (adapt_step_q),
			.fg        (fg_ch[c]),
			.nb        (nb[c])
		);
	end

	assign s2_fg = s2_in_range && (s2_color ? (|fg_ch) : fg_ch[0]);
	assign s2_wr = s2_in_range && ((s2_op == OP_LOAD) || s2_update);
	assign wr_data = (s2_op == OP_LOAD) ? pix_s2 : nb;

	always_ff @(posedge clk) begin
		if (s2_go && s2_wr) begin
			for (int c = 0; c < CH_N; c++) begin
				if (s2_mask[c]) begin
					bg_mem[s2_addr][c] <= wr_data[c];
				end
			end
			wb_addr_q <= s2_addr;
			wb_mask_q <= s2_mask;
			wb_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid && (s2_op == OP_DETECT)) begin
			out_fg_q <= s2_fg;
			out_index_q <= s2_index;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_index_q, out_fg_q};

endmodule

// File: hw/rtl/ambs_check.sv
// port-level checker for the approximate-median background subtractor, with its bind
`include "approx_median_background_subtract_assert.svh"

module ambs_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ambs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ambs_pkg::*;

	// no result word is pending right after reset
	`AMBS_ASSERT_RST(a_rst_empty, $rose(arst_n) |-> !m_axis_tvalid, "result valid after reset")

	// a stalled result word holds
	`AMBS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// with room at the output the whole pipeline drains, so input is taken
	`AMBS_ASSERT(a_ready_free, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled with free output")

	// fill bits of the result word stay zero
	`AMBS_ASSERT(a_out_fill, m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0), "result fill bits set")

endmodule

bind approx_median_background_subtract ambs_check u_ambs_check (.*);

// File: dv/testbench.sv
// self-checking testbench for the approximate-median background subtractor
import ambs_pkg::*;

class fg_predictor;
	typedef struct packed {
		logic [CH_N-1:0][FIX_W-1:0] ch;
		logic [CH_N-1:0] loaded;
	} pel_t;

	typedef struct packed {
		logic fg;
		logic [IDX_W-1:0] idx;
	} flag_t;

	pel_t bg_store[logic [IDX_W-1:0]];
	flag_t flag_q[$];
	logic [CFG_W-1:0] threshold = THRESHOLD_RST;
	logic [CFG_W-1:0] adapt_step = ADAPT_STEP_RST;
	logic [MODE_W-1:0] pixel_mode = PIXEL_MODE_RST;
	int errors = 0;

	function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
		case (index)
			REG_THRESHOLD: threshold = value;
			REG_ADAPT_STEP: adapt_step = value;
			REG_PIXEL_MODE: pixel_mode = value[MODE_W-1:0];
			default: ;
		endcase
	endfunction

	// the spare mode code falls back to plain gray
	function logic [MODE_W-1:0] eff_mode();
		return (pixel_mode == MODE_UNUSED) ? MODE_GRAY : pixel_mode;
	endfunction

	// a detect may only touch channels that were loaded before
	function bit detect_allowed(logic [IDX_W-1:0] idx);
		if (!bg_store.exists(idx))
			return 1'b0;
		if (eff_mode() == MODE_COLOR)
			return bg_store[idx].loaded == '1;
		return bg_store[idx].loaded[0];
	endfunction

	function logic [PIX_W-1:0] luma(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] r);
		int unsigned s;
		s = int'(B2Y) * b + int'(G2Y) * g + int'(R2Y) * r;
		return PIX_W'(s >> Y_SHIFT);
	endfunction

	function bit channel_flag(inout logic [FIX_W-1:0] slot, input logic [PIX_W-1:0] pix,
			input logic upd);
		int bg_v;
		int img;
		int diff;
		int nb;
		bit fg;
		bg_v = int'(slot);
		img = int'(pix) << FRAC_W;
		diff = (img > bg_v) ? img - bg_v : bg_v - img;
		fg = diff > int'(threshold);
		if (upd) begin
			nb = bg_v;
			if (bg_v < img)
				nb = bg_v + int'(adapt_step);
			else if (bg_v > img)
				nb = bg_v - int'(adapt_step);
			if (nb < 0)
				nb = 0;
			else if (nb > int'(FIX_TOP))
				nb = int'(FIX_TOP);
			slot = FIX_W'(nb);
		end
		return fg;
	endfunction

	function void note_pixel(logic op, logic [IDX_W-1:0] idx, logic [PIX_W-1:0] b,
			logic [PIX_W-1:0] g, logic [PIX_W-1:0] r, logic upd);
		pel_t e;
		flag_t f;
		logic [FIX_W-1:0] c0;
		logic [FIX_W-1:0] c1;
		logic [FIX_W-1:0] c2;
		logic [PIX_W-1:0] v;
		bit fg;
		e = '0;
		if (bg_store.exists(idx))
			e = bg_store[idx];
		if (op == OP_LOAD) begin
			if (eff_mode() == MODE_COLOR) begin
				e.ch[0] = {b, {FRAC_W{1'b0}}};
				e.ch[1] = {g, {FRAC_W{1'b0}}};
				e.ch[2] = {r, {FRAC_W{1'b0}}};
				e.loaded = '1;
			end else begin
				v = (eff_mode() == MODE_BGR) ? luma(b, g, r) : b;
				e.ch[0] = {v, {FRAC_W{1'b0}}};
				e.loaded[0] = 1'b1;
			end
			bg_store[idx] = e;
			return;
		end
		c0 = e.ch[0];
		c1 = e.ch[1];
		c2 = e.ch[2];
		if (eff_mode() == MODE_COLOR) begin
			fg = channel_flag(c0, b, upd);
			fg = channel_flag(c1, g, upd) | fg;
			fg = channel_flag(c2, r, upd) | fg;
		end else begin
			v = (eff_mode() == MODE_BGR) ? luma(b, g, r) : b;
			fg = channel_flag(c0, v, upd);
		end
		e.ch[0] = c0;
		e.ch[1] = c1;
		e.ch[2] = c2;
		bg_store[idx] = e;
		f.fg = fg;
		f.idx = idx;
		flag_q.push_back(f);
	endfunction

	task report_mismatch(string what);
		errors++;
		if (errors <= 30)
			$display("mismatch: %s", what);
	endtask

	task check_flag(logic [OUT_TDATA_W-1:0] word);
		flag_t f;
		if (flag_q.size() == 0) begin
			report_mismatch($sformatf("flag word %h with nothing outstanding", word));
			return;
		end
		f = flag_q.pop_front();
		if (word[0] !== f.fg)
			report_mismatch($sformatf("pixel %h: foreground %b, predicted %b",
				f.idx, word[0], f.fg));
		if (word[IDX_W:1] !== f.idx)
			report_mismatch($sformatf("pixel index %h, predicted %h", word[IDX_W:1], f.idx));
	endtask
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOT_PIXELS = 24;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 140;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	fg_predictor pred = new();
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	logic [IDX_W-1:0] hot_idx[HOT_PIXELS];
	logic [IDX_W-1:0] last_idx = '0;

	approx_median_background_subtract dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	// flag receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_gaps || ($urandom_range(99) >= 12);
			end
			// handshake values are stable at the falling edge
			@(negedge clk);
			if (m_axis_tvalid && m_axis_tready)
				pred.check_flag(m_axis_tdata);
		end
	end

	task automatic send_pixel(input logic op, input logic [IDX_W-1:0] idx,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] r, input logic upd);
		bit taken;
		while (!no_gaps && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= IN_TDATA_W'({upd, r, g, b, idx});
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end
		pred.note_pixel(op, idx, b, g, r, upd);
		last_idx = idx;
	endtask

	task automatic wait_flags();
		s_axis_tvalid <= 1'b0;
		while (pred.flag_q.size() != 0)
			@(posedge clk);
	endtask

	// loads leave no flag, so also let the pipeline empty after the last flag is in
	task automatic settle();
		wait_flags();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] step,
			input logic [MODE_W-1:0] mode);
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_ADAPT_STEP;
		cfg_data <= step;
		@(posedge clk);
		cfg_index <= REG_PIXEL_MODE;
		cfg_data <= CFG_W'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		pred.write_reg(REG_THRESHOLD, thr);
		pred.write_reg(REG_ADAPT_STEP, step);
		pred.write_reg(REG_PIXEL_MODE, CFG_W'(mode));
	endtask

	// pixel value close to a stored channel, often right at the threshold distance
	function automatic logic [PIX_W-1:0] near_pixel(logic [FIX_W-1:0] ch);
		int v;
		int d;
		d = ($urandom_range(2) == 0) ? int'(pred.threshold >> FRAC_W) : $urandom_range(2);
		d = d + $urandom_range(1);
		v = int'(ch >> FRAC_W) + (($urandom_range(1) == 0) ? d : -d);
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return PIX_W'(v);
	endfunction

	task automatic random_pixel();
		logic [IDX_W-1:0] idx;
		logic op;
		logic [PIX_W-1:0] px[CH_N];
		logic upd;
		int k;
		k = $urandom_range(99);
		if (k < 20)
			idx = last_idx;
		else if (k < 80)
			idx = hot_idx[$urandom_range(HOT_PIXELS - 1)];
		else
			idx = IDX_W'($urandom);
		op = ($urandom_range(99) < 70) ? OP_DETECT : OP_LOAD;
		if (!pred.detect_allowed(idx))
			op = OP_LOAD;
		for (int c = 0; c < CH_N; c++) begin
			px[c] = PIX_W'($urandom);
			if (op == OP_DETECT && $urandom_range(2) != 0) begin
				if (pred.bg_store[idx].loaded[c])
					px[c] = near_pixel(pred.bg_store[idx].ch[c]);
			end
		end
		upd = $urandom_range(99) < 75;
		send_pixel(op, idx, px[0], px[1], px[2], upd);
	endtask

	initial begin
		logic [CFG_W-1:0] thr;
		logic [CFG_W-1:0] step;
		logic [MODE_W-1:0] mode;
		for (int i = 0; i < HOT_PIXELS; i++)
			hot_idx[i] = IDX_W'($urandom);
		hot_idx[0] = '0;
		hot_idx[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: gray, threshold 30 pixels, step one pixel
		send_pixel(OP_LOAD, 20'h00000, 8'd0, 8'd255, 8'd255, 1'b0);
		send_pixel(OP_LOAD, 20'hFFFFF, 8'd255, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_LOAD, 20'h00005, 8'd100, 8'd0, 8'd0, 1'b0);
		send_pixel(OP_DETECT, 20'h00000, 8'd255, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_DETECT, 20'h00000, 8'd0, 8'd0, 8'd0, 1'b1);
		// background at the floor and equal to the pixel
		send_pixel(OP_DETECT, 20'h00000, 8'd0, 8'd255, 8'd255, 1'b1);
		send_pixel(OP_DETECT, 20'hFFFFF, 8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_DETECT, 20'hFFFFF, 8'd255, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_DETECT, 20'hFFFFF, 8'd255, 8'd0, 8'd0, 1'b1);
		// difference exactly at the threshold and one above, both sides
		send_pixel(OP_DETECT, 20'h00005, 8'd130, 8'd0, 8'd0, 1'b0);
		send_pixel(OP_DETECT, 20'h00005, 8'd131, 8'd0, 8'd0, 1'b0);
		send_pixel(OP_DETECT, 20'h00005, 8'd70, 8'd0, 8'd0, 1'b0);
		send_pixel(OP_DETECT, 20'h00005, 8'd69, 8'd0, 8'd0, 1'b1);
		// back-to-back updates of one pixel
		send_pixel(OP_DETECT, 20'h00005, 8'd100, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_DETECT, 20'h00005, 8'd100, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_DETECT, 20'h00005, 8'd100, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_LOAD, 20'h00005, 8'd200, 8'd0, 8'd0, 1'b0);
		send_pixel(OP_DETECT, 20'h00005, 8'd200, 8'd0, 8'd0, 1'b1);
		send_pixel(OP_DETECT, 20'h00000, 8'd255, 8'd255, 8'd255, 1'b0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			thr = ($urandom_range(1) == 0) ? CFG_W'($urandom_range(40) * 16)
				: CFG_W'($urandom);
			step = ($urandom_range(3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(64));
			case (p)
				0: begin
					thr = '0;
					step = '0;
					mode = MODE_GRAY;
				end
				1: begin
					thr = '1;
					step = '1;
					mode = MODE_COLOR;
				end
				2: begin
					thr = '0;
					step = '1;
					mode = MODE_BGR;
				end
				3: begin
					thr = '1;
					step = '0;
					mode = MODE_UNUSED;
				end
				4: mode = MODE_W'($urandom_range(3));
				5: mode = MODE_COLOR;
				6: mode = MODE_GRAY;
				default: mode = MODE_BGR;
			endcase
			set_regs(thr, step, mode);
			no_gaps = (p == 2);
			if (p == 1 || p == 5)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 4 && n == PHASE_WORDS / 2)
					wait_flags();
				random_pixel();
			end
			settle();
		end
		no_gaps = 1'b0;

		if (pred.errors == 0 && pred.flag_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
